### hw/rtl/heightmap_window_smooth_defines.svh
// Assertion macros shared by the heightmap smoothing block.
`ifndef HEIGHTMAP_WINDOW_SMOOTH_DEFINES_SVH
`define HEIGHTMAP_WINDOW_SMOOTH_DEFINES_SVH

// Assert that an antecedent implies a consequent on the next edge.
`define HWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

// Assert that an antecedent implies a consequent on the same edge.
`define HWS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

### hw/rtl/hws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hws_pkg;
	localparam int MAX_DIM_DEF     = 256;
	localparam int MAX_BRUSH_DEF   = 32;
	localparam int HEIGHT_BITS_DEF = 24;

	localparam int DIM_W    = 9;
	localparam int BLEND_W  = 16;
	localparam int COORD_W  = 8;
	localparam int HEIGHT_W = 24;
	localparam int RADIUS_W = 6;
	localparam int COUNT_W  = 13;
	localparam int STATUS_W = 2;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SMOOTH = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_FACTOR = 2'd2;

	localparam logic [DIM_W-1:0]   GRID_WIDTH_RST   = 9'd129;
	localparam logic [DIM_W-1:0]   GRID_DEPTH_RST   = 9'd129;
	localparam logic [BLEND_W-1:0] BLEND_FACTOR_RST = 16'd1966;

	typedef struct packed {
		logic [KIND_W-1:0]          kind;
		logic [COORD_W-1:0]         pos_x;
		logic [COORD_W-1:0]         pos_z;
		logic signed [HEIGHT_W-1:0] height_in;
		logic [RADIUS_W-1:0]        brush_radius;
	} in_beat_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height_out;
		logic [STATUS_W-1:0]        status;
		logic [COUNT_W-1:0]         sample_count;
	} out_beat_t;
endpackage
`default_nettype wire

### hw/rtl/hws_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module hws_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 13
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den,
	output logic                         busy,
	output logic                         done,
	output logic signed [NUM_W-1:0]      quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign quot  = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			neg_q <= num[NUM_W-1];
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			if (!diff[DEN_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/hws_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Height memory, one write and one registered read per cycle.
module hws_store #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0]      rdata
);
	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/heightmap_window_smooth.sv
`timescale 1ns / 1ps
`default_nettype none
// Heightmap store with box-average smoothing.
// in channel (in_valid/in_stall/in_data): one beat per command: write, read or smooth.
// out channel (out_valid/out_stall/out_data): exactly one result beat per command.
// cfg port: grid_width, grid_depth, blend_factor by index; write only while idle.
// Commands run one at a time; in_stall stays high until the result register frees.
// A write or out-of-grid command goes from S_DECODE straight to S_OUT; a read passes S_READ.
// Smooth walks the (2r)^2 window twice through the single store read port at one
// sample per cycle (a window row outside the grid is skipped whole), with a 38-bit
// bit-serial divider between the passes and a single 26x17 multiply per updated
// sample.
// Reset clears control and restores register defaults; the height memory is not
// cleared and must be written before being read.
// A stalled result holds in the output register; the next command waits for it.
module heightmap_window_smooth #(
	parameter int MAX_DIM     = hws_pkg::MAX_DIM_DEF,
	parameter int MAX_BRUSH   = hws_pkg::MAX_BRUSH_DEF,
	parameter int HEIGHT_BITS = hws_pkg::HEIGHT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire hws_pkg::in_beat_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output hws_pkg::out_beat_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [hws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hws_pkg::BLEND_W-1:0]   cfg_data
);
	`include "heightmap_window_smooth_defines.svh"

	localparam int AXIS_W = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * AXIS_W;
	localparam int POS_W  = (AXIS_W > hws_pkg::COORD_W) ? AXIS_W : hws_pkg::COORD_W;
	localparam int CRD_W  = POS_W + 2;
	localparam int BR_W   = $clog2(MAX_BRUSH + 1);
	localparam int CNT_W  = 2 * BR_W + 1;
	localparam int SUM_W  = HEIGHT_BITS + 2 * BR_W + 2;
	localparam int DIFF_W = HEIGHT_BITS + 2;
	localparam int PROD_W = DIFF_W + hws_pkg::BLEND_W + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_READ, S_SUM, S_DIV, S_UPD, S_OUT
	} state_t;

	state_t state_q;
	hws_pkg::in_beat_t cmd_q;
	logic [hws_pkg::DIM_W-1:0]   grid_width_q, grid_depth_q;
	logic [hws_pkg::BLEND_W-1:0] blend_q;
	logic [AXIS_W:0] w_lim, d_lim;
	logic [BR_W-1:0] r_q;
	logic signed [CRD_W-1:0] x_q, z_q, x_lo_q, x_hi_q, z_hi_q;
	logic signed [SUM_W-1:0] sum_q, avg_q;
	logic [CNT_W-1:0] count_q;
	logic pass_q;
	logic rd_v_s1, rd_v_s2, rd_v_s3;
	logic [ADDR_W-1:0] addr_s1, addr_s2;
	logic signed [HEIGHT_BITS-1:0] h_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [HEIGHT_BITS-1:0] wdata, rdata;
	logic cur_in;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [PROD_W-1:0] prod_c, step_c, new_c;
	logic signed [HEIGHT_BITS-1:0] new_h;
	logic signed [PROD_W-1:0] wr_ext;
	logic div_start, div_busy, div_done;
	logic signed [SUM_W-1:0] quot;

	localparam logic signed [PROD_W-1:0] H_MAX = PROD_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 1);
	localparam logic signed [PROD_W-1:0] H_MIN = -H_MAX - 1;
	localparam logic signed [CRD_W-1:0]  CRD_ONE = 1;

	assign w_lim = (int'(grid_width_q) > MAX_DIM) ? (AXIS_W+1)'(MAX_DIM)
	                                             : (AXIS_W+1)'(grid_width_q);
	assign d_lim = (int'(grid_depth_q) > MAX_DIM) ? (AXIS_W+1)'(MAX_DIM)
	                                             : (AXIS_W+1)'(grid_depth_q);

	assign in_stall = (state_q != S_IDLE);
	assign cur_in = (x_q >= 0) && (x_q < $signed({1'b0, w_lim}));

	hws_store #(.ADDR_W(ADDR_W), .DATA_W(HEIGHT_BITS)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	hws_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(sum_q), .den(count_q),
		.busy(div_busy), .done(div_done), .quot(quot)
	);
	assign div_start = (state_q == S_SUM) && !rd_v_s1 && !rd_v_s2 && !pass_q
	                   && (count_q != '0) && (z_q >= z_hi_q);

	assign raddr = {z_q[AXIS_W-1:0], x_q[AXIS_W-1:0]};

	// sample update: h + trunc((avg - h) * blend / 65536), saturated to the height range
	assign diff_s2 = DIFF_W'(avg_q) - DIFF_W'($signed(rdata));
	assign prod_c  = diff_s2 * $signed({1'b0, blend_q});
	assign step_c = prod_s3[PROD_W-1] ? -((-prod_s3) >>> hws_pkg::BLEND_W)
	                                  : (prod_s3 >>> hws_pkg::BLEND_W);
	assign new_c  = PROD_W'(h_s3) + step_c;
	assign new_h  = (new_c > H_MAX) ? HEIGHT_BITS'(H_MAX)
	              : (new_c < H_MIN) ? HEIGHT_BITS'(H_MIN) : HEIGHT_BITS'(new_c);

	assign wr_ext = PROD_W'($signed(cmd_q.height_in));
	always_comb begin
		we = 1'b0;
		waddr = addr_s2;
		wdata = new_h;
		if (state_q == S_UPD && rd_v_s2) begin
			we = 1'b1;
		end else if (state_q == S_DECODE && cmd_q.kind == hws_pkg::KIND_WRITE
		             && x_q < $signed({1'b0, w_lim}) && z_q < $signed({1'b0, d_lim})) begin
			we = 1'b1;
			waddr = raddr;
			wdata = (wr_ext > H_MAX) ? HEIGHT_BITS'(H_MAX)
			      : (wr_ext < H_MIN) ? HEIGHT_BITS'(H_MIN) : HEIGHT_BITS'(wr_ext);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
		addr_s2 <= addr_s1;
		h_s3    <= $signed(rdata);
		prod_s3 <= prod_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= hws_pkg::GRID_WIDTH_RST;
			grid_depth_q <= hws_pkg::GRID_DEPTH_RST;
			blend_q      <= hws_pkg::BLEND_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hws_pkg::REG_GRID_WIDTH:   grid_width_q <= cfg_data[hws_pkg::DIM_W-1:0];
				hws_pkg::REG_GRID_DEPTH:   grid_depth_q <= cfg_data[hws_pkg::DIM_W-1:0];
				hws_pkg::REG_BLEND_FACTOR: blend_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			rd_v_s1   <= 1'b0;
			rd_v_s2   <= 1'b0;
			rd_v_s3   <= 1'b0;
			pass_q    <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= rd_v_s1;
			rd_v_s3 <= rd_v_s2;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_data;
						x_q     <= CRD_W'(in_data.pos_x);
						z_q     <= CRD_W'(in_data.pos_z);
						r_q     <= (int'(in_data.brush_radius) > MAX_BRUSH)
						           ? BR_W'(MAX_BRUSH) : BR_W'(in_data.brush_radius);
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					out_data <= '0;
					sum_q    <= '0;
					count_q  <= '0;
					pass_q   <= 1'b0;
					x_lo_q   <= x_q - CRD_W'(r_q);
					x_hi_q   <= x_q + CRD_W'(r_q);
					z_hi_q   <= z_q + CRD_W'(r_q);
					if (x_q >= $signed({1'b0, w_lim}) || z_q >= $signed({1'b0, d_lim})) begin
						out_data.status <= (cmd_q.kind == hws_pkg::KIND_UNUSED)
						                   ? hws_pkg::ST_OK : hws_pkg::ST_RANGE;
						state_q <= S_OUT;
					end else begin
						unique case (cmd_q.kind)
							hws_pkg::KIND_READ:   state_q <= S_READ;
							hws_pkg::KIND_SMOOTH: begin
								if (r_q == '0) begin
									out_data.status <= hws_pkg::ST_EMPTY;
									state_q <= S_OUT;
								end else begin
									x_q <= x_q - CRD_W'(r_q);
									z_q <= z_q - CRD_W'(r_q);
									state_q <= S_SUM;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_READ: begin
					if (rd_v_s1) begin
						out_data.height_out <= hws_pkg::HEIGHT_W'($signed(rdata));
						state_q <= S_OUT;
					end else begin
						rd_v_s1 <= 1'b1;
					end
				end
				S_SUM, S_UPD: begin
					if (z_q < z_hi_q) begin
						if (z_q < 0 || z_q >= $signed({1'b0, d_lim})) begin
							z_q <= z_q + CRD_ONE;
						end else begin
							rd_v_s1 <= cur_in;
							if (x_q + CRD_ONE >= x_hi_q) begin
								x_q <= x_lo_q;
								z_q <= z_q + CRD_ONE;
							end else begin
								x_q <= x_q + CRD_ONE;
							end
						end
					end
					if (state_q == S_SUM && rd_v_s1) begin
						sum_q   <= sum_q + SUM_W'($signed(rdata));
						count_q <= count_q + 1'b1;
					end
					if (z_q >= z_hi_q && !rd_v_s1 && !rd_v_s2 && !rd_v_s3) begin
						if (state_q == S_UPD) begin
							out_data.height_out <= hws_pkg::HEIGHT_W'(avg_q);
							out_data.sample_count <= hws_pkg::COUNT_W'(count_q);
							state_q <= S_OUT;
						end else if (count_q == '0) begin
							out_data.status <= hws_pkg::ST_EMPTY;
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						avg_q   <= quot;
						x_q     <= x_lo_q;
						z_q     <= z_hi_q - CRD_W'(2 * r_q);
						pass_q  <= 1'b1;
						state_q <= S_UPD;
					end
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HWS_ASSERT_NOW(a_out_only_in_out, clk, arst_n, out_valid, state_q == S_OUT, "result outside output state")
	`HWS_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall, "accepted beat did not block input")
	`HWS_ASSERT_NOW(a_update_after_div, clk, arst_n, we && state_q == S_UPD, pass_q, "update write before division")
	`HWS_ASSERT_NOW(a_div_in_smooth, clk, arst_n, div_busy, state_q == S_SUM || state_q == S_DIV, "divider busy outside smooth")
endmodule
`default_nettype wire

### tb/sv/heightmap_window_smooth_tb.sv
`timescale 1ns / 1ps
module heightmap_window_smooth_tb;
	localparam int DIM = hws_pkg::MAX_DIM_DEF;
	localparam int BRUSH = hws_pkg::MAX_BRUSH_DEF;
	localparam int STALL_LIMIT = 60000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	hws_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	hws_pkg::out_beat_t out_data;
	logic cfg_we;
	logic [hws_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [hws_pkg::BLEND_W-1:0] cfg_data;

	heightmap_window_smooth u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	hws_pkg::in_beat_t cmd_q[$];
	hws_pkg::out_beat_t result_q[$];
	longint height_mem[DIM*DIM];
	bit cell_written[DIM*DIM];
	int grid_w;
	int grid_d;
	int blend;
	int errors;
	int cyc;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit may_idle();
		return !(cyc >= 400 && cyc < 1200) && ($urandom_range(0, 99) < 37);
	endfunction

	function automatic int eff_dim(int v);
		return (v > DIM) ? DIM : v;
	endfunction

	function automatic hws_pkg::out_beat_t smooth_predict(hws_pkg::in_beat_t c);
		hws_pkg::out_beat_t res;
		int w;
		int d;
		int r;
		int px;
		int pz;
		int cnt;
		longint sum;
		longint avg;
		longint h;
		w = eff_dim(grid_w);
		d = eff_dim(grid_d);
		px = int'(c.pos_x);
		pz = int'(c.pos_z);
		res = '0;
		if (c.kind == hws_pkg::KIND_UNUSED)
			return res;
		if (px >= w || pz >= d) begin
			res.status = hws_pkg::ST_RANGE;
			return res;
		end
		case (c.kind)
			hws_pkg::KIND_WRITE: height_mem[pz*DIM + px] = longint'(c.height_in);
			hws_pkg::KIND_READ: res.height_out = height_mem[pz*DIM + px][hws_pkg::HEIGHT_W-1:0];
			default: begin
				r = (int'(c.brush_radius) > BRUSH) ? BRUSH : int'(c.brush_radius);
				sum = 0;
				cnt = 0;
				for (int z = pz - r; z < pz + r; z++)
					for (int x = px - r; x < px + r; x++)
						if (z >= 0 && z < d && x >= 0 && x < w) begin
							sum += height_mem[z*DIM + x];
							cnt++;
						end
				if (cnt == 0) begin
					res.status = hws_pkg::ST_EMPTY;
				end else begin
					avg = sum / cnt;
					for (int z = pz - r; z < pz + r; z++)
						for (int x = px - r; x < px + r; x++)
							if (z >= 0 && z < d && x >= 0 && x < w) begin
								h = height_mem[z*DIM + x];
								height_mem[z*DIM + x] = h + ((avg - h) * blend) / 65536;
							end
					res.height_out = avg[hws_pkg::HEIGHT_W-1:0];
					res.sample_count = cnt[hws_pkg::COUNT_W-1:0];
				end
			end
		endcase
		return res;
	endfunction

	function automatic void add_cmd(int k, int x, int z, int h, int r);
		hws_pkg::in_beat_t c;
		c.kind = k[hws_pkg::KIND_W-1:0];
		c.pos_x = x[hws_pkg::COORD_W-1:0];
		c.pos_z = z[hws_pkg::COORD_W-1:0];
		c.height_in = h[hws_pkg::HEIGHT_W-1:0];
		c.brush_radius = r[hws_pkg::RADIUS_W-1:0];
		cmd_q.push_back(c);
	endfunction

	// fill every in-grid cell of the box not yet written with a write so that no read hits an empty cell
	function automatic void fill_box(int x0, int x1, int z0, int z1);
		int w;
		int d;
		w = eff_dim(grid_w);
		d = eff_dim(grid_d);
		for (int z = z0; z <= z1; z++)
			for (int x = x0; x <= x1; x++)
				if (z >= 0 && z < d && x >= 0 && x < w && !cell_written[z*DIM + x]) begin
					cell_written[z*DIM + x] = 1'b1;
					add_cmd(hws_pkg::KIND_WRITE, x, z, $urandom, 0);
				end
	endfunction

	function automatic void add_read(int x, int z);
		fill_box(x, x, z, z);
		add_cmd(hws_pkg::KIND_READ, x, z, $urandom, $urandom);
	endfunction

	function automatic void add_smooth(int x, int z, int r);
		int re;
		re = (r > BRUSH) ? BRUSH : r;
		if (x < eff_dim(grid_w) && z < eff_dim(grid_d) && re > 0)
			fill_box(x - re, x + re - 1, z - re, z + re - 1);
		add_cmd(hws_pkg::KIND_SMOOTH, x, z, $urandom, r);
	endfunction

	function automatic int pick_coord(int lim);
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, eff_dim(lim) - 1);
		return $urandom_range(0, 255);
	endfunction

	function automatic void add_random(int n);
		int x;
		int z;
		int r;
		int sel;
		for (int i = 0; i < n; i++) begin
			x = pick_coord(grid_w);
			z = pick_coord(grid_d);
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				if (x < eff_dim(grid_w) && z < eff_dim(grid_d))
					cell_written[z*DIM + x] = 1'b1;
				add_cmd(hws_pkg::KIND_WRITE, x, z, $urandom, $urandom);
			end else if (sel < 60) begin
				add_read(x, z);
			end else if (sel < 95) begin
				if (eff_dim(grid_w) * eff_dim(grid_d) <= 64)
					r = $urandom_range(0, 63);
				else if ($urandom_range(0, 9) < 8)
					r = $urandom_range(0, 1);
				else
					r = 2;
				add_smooth(x, z, r);
			end else begin
				add_cmd(hws_pkg::KIND_UNUSED, x, z, $urandom, $urandom);
			end
		end
	endfunction

	task automatic drain();
		while (cmd_q.size() != 0 || in_valid || result_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_grid(int w, int d, int b);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= hws_pkg::REG_GRID_WIDTH;
		cfg_data <= w[hws_pkg::BLEND_W-1:0];
		@(posedge clk);
		cfg_index <= hws_pkg::REG_GRID_DEPTH;
		cfg_data <= d[hws_pkg::BLEND_W-1:0];
		@(posedge clk);
		cfg_index <= hws_pkg::REG_BLEND_FACTOR;
		cfg_data <= b[hws_pkg::BLEND_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_w = w;
		grid_d = d;
		blend = b;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				result_q.push_back(smooth_predict(in_data));
			if (!in_valid || !in_stall) begin
				if (cmd_q.size() != 0 && !may_idle()) begin
					in_data <= cmd_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		hws_pkg::out_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$display("%0t unexpected beat: expected none actual %h", $time, out_data);
					errors++;
				end else begin
					want = result_q.pop_front();
					if (out_data.height_out !== want.height_out) begin
						$display("%0t height_out: expected %h actual %h", $time,
							want.height_out, out_data.height_out);
						errors++;
					end
					if (out_data.status !== want.status) begin
						$display("%0t status: expected %h actual %h", $time,
							want.status, out_data.status);
						errors++;
					end
					if (out_data.sample_count !== want.sample_count) begin
						$display("%0t sample_count: expected %0d actual %0d", $time,
							want.sample_count, out_data.sample_count);
						errors++;
					end
				end
			end
			out_stall <= may_idle();
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cyc = 0;
		quiet_cycles = 0;
		grid_w = hws_pkg::GRID_WIDTH_RST;
		grid_d = hws_pkg::GRID_DEPTH_RST;
		blend = hws_pkg::BLEND_FACTOR_RST;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		cell_written[0] = 1'b1;
		add_cmd(hws_pkg::KIND_WRITE, 0, 0, 24'h7fffff, 63);
		cell_written[128*DIM + 128] = 1'b1;
		add_cmd(hws_pkg::KIND_WRITE, 128, 128, 24'h800000, 0);
		add_read(0, 0);
		add_read(128, 128);
		add_cmd(hws_pkg::KIND_WRITE, 129, 0, 24'h123456, 0);
		add_cmd(hws_pkg::KIND_READ, 0, 255, 0, 0);
		add_cmd(hws_pkg::KIND_SMOOTH, 255, 3, 0, 4);
		add_smooth(5, 5, 0);
		add_smooth(0, 0, 1);
		add_smooth(128, 128, 2);
		add_read(127, 127);
		add_smooth(64, 64, 1);
		add_cmd(hws_pkg::KIND_UNUSED, 255, 255, 24'hffffff, 63);
		add_random(5);
		drain();

		set_grid(5, 4, 65535);
		add_smooth(2, 2, 32);
		add_random(8);
		drain();

		set_grid(1, 1, 0);
		add_smooth(0, 0, 5);
		add_random(8);
		drain();

		set_grid(256, 256, 32768);
		add_smooth(255, 255, 2);
		add_read(255, 0);
		add_random(4);
		drain();

		set_grid(511, 37, 12345);
		add_random(4);
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
